// File: sv/tfd_pkg.sv
// Shared types, codes and constants of the telemetry frame deframer.
package tfd_pkg;

  localparam logic [7:0] SYNC_BYTE0 = 8'hAA;
  localparam logic [7:0] SYNC_BYTE1 = 8'h55;
  localparam logic [3:0] GROUP_BYTES = 4'd12;
  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned GROUP_BITS = 8 * WORD_BYTES * 3;
  localparam int unsigned TDATA_W = 136;

  localparam logic REG_TELEMETRY_TYPE = 1'b0;
  localparam logic REG_LOG_TYPE = 1'b1;

  typedef enum logic [2:0] {
    KIND_JOINT = 3'd0,
    KIND_TEL_END = 3'd1,
    KIND_LOG = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_CSUM_BAD = 3'd4,
    KIND_OVERSIZE = 3'd5,
    KIND_SHORT = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_SYNC,
    ST_LENLO,
    ST_LENHI,
    ST_BODY,
    ST_CHECK,
    ST_EVAL0,
    ST_EVAL1,
    ST_JCHK,
    ST_JFETCH,
    ST_JOUT,
    ST_ENDRD,
    ST_ENDOUT,
    ST_LOGRD,
    ST_LOGOUT
  } state_t;

  typedef struct packed {
    logic [6:0] pad;
    logic first_frame;
    logic [15:0] message_length;
    logic [1:0] log_level;
    logic [7:0] state_byte;
    logic [31:0] accel_word;
    logic [31:0] velocity_word;
    logic [31:0] position_word;
    logic [5:0] joint_index;
  } record_t;

  typedef struct packed {
    logic len_lo_ld;
    logic len_hi_ld;
    logic body_wr;
    logic check_ld;
    logic eval;
    logic ptr_set1;
    logic fetch_adv;
    logic fetch_shift;
    logic jidx_inc;
    logic out_ld;
    kind_t out_kind;
    logic out_first_en;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic sync0;
    logic sync1;
    logic len_over;
    logic len_zero;
    logic body_last;
    logic chk_bad;
    logic flen_zero;
    logic flen_lt2;
    logic type_tel;
    logic type_log;
    logic group_fits;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic we;
    logic sel;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

// File: sv/tfd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tfd_datapath.sv
// Datapath of the deframer: length, checksum, payload memory, joint assembly, output register.
module tfd_datapath import tfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 512
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output status_t status,
  input  logic [7:0] rx_byte,
  input  cfg_wr_t cfg_wr,
  input  logic cfg_rsel,
  output logic [31:0] cfg_rdata,
  output logic out_valid,
  input  logic out_ready,
  output record_t out_rec,
  output kind_t out_kind,
  output logic out_last
);

  localparam int PTR_W = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W = $clog2(MAX_PAYLOAD);

  logic [7:0] telemetry_type;
  logic [7:0] log_type;
  logic [7:0] len_lo;
  logic [PTR_W-1:0] len;
  logic [PTR_W-1:0] byte_count;
  logic [PTR_W-1:0] rd_ptr;
  logic [7:0] running_xor;
  logic chk_bad;
  logic valid_seen;
  logic first_reg;
  logic [5:0] jidx;
  logic [GROUP_BITS-1:0] group_sr;
  logic [7:0] ram_q;
  logic [15:0] len_full;
  logic good;
  record_t rec_next;

  assign len_full = {rx_byte, len_lo};
  assign good = !chk_bad && (len != '0);

  tfd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_payload (
    .clk(clk),
    .we(cmd.body_wr),
    .waddr(byte_count[ADDR_W-1:0]),
    .wdata(rx_byte),
    .raddr(rd_ptr[ADDR_W-1:0]),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      telemetry_type <= 8'd1;
      log_type <= 8'd240;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.sel)
        REG_TELEMETRY_TYPE: telemetry_type <= cfg_wr.data;
        REG_LOG_TYPE: log_type <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_rsel)
      REG_TELEMETRY_TYPE: cfg_rdata = {24'd0, telemetry_type};
      REG_LOG_TYPE: cfg_rdata = {24'd0, log_type};
      default: cfg_rdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.len_lo_ld) begin
      len_lo <= rx_byte;
    end
    if (cmd.len_hi_ld) begin
      len <= len_full[PTR_W-1:0];
      byte_count <= '0;
      running_xor <= '0;
    end
    if (cmd.body_wr) begin
      byte_count <= byte_count + 1'b1;
      running_xor <= running_xor ^ rx_byte;
    end
    if (cmd.check_ld) begin
      chk_bad <= (rx_byte != running_xor);
      rd_ptr <= '0;
    end
    if (cmd.eval) begin
      first_reg <= good && !valid_seen;
    end
    if (cmd.ptr_set1) begin
      rd_ptr <= PTR_W'(1);
      jidx <= '0;
    end
    if (cmd.fetch_adv) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
    if (cmd.fetch_shift) begin
      group_sr <= {ram_q, group_sr[GROUP_BITS-1:8]};
    end
    if (cmd.jidx_inc) begin
      jidx <= jidx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_seen <= 1'b0;
    end else if (cmd.eval && good) begin
      valid_seen <= 1'b1;
    end
  end

  always_comb begin
    rec_next = '0;
    rec_next.first_frame = cmd.out_first_en & first_reg;
    case (cmd.out_kind)
      KIND_JOINT: begin
        rec_next.joint_index = jidx;
        rec_next.position_word = group_sr[31:0];
        rec_next.velocity_word = group_sr[63:32];
        rec_next.accel_word = group_sr[95:64];
      end
      KIND_TEL_END: rec_next.state_byte = ram_q;
      KIND_LOG: begin
        rec_next.log_level = (ram_q > 8'd3) ? 2'd0 : ram_q[1:0];
        rec_next.message_length = 16'(len) - 16'd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_rec <= rec_next;
      out_kind <= cmd.out_kind;
      out_last <= cmd.out_last;
    end
  end

  always_comb begin
    status.sync0 = (rx_byte == SYNC_BYTE0);
    status.sync1 = (rx_byte == SYNC_BYTE1);
    status.len_over = (len_full > 16'(MAX_PAYLOAD));
    status.len_zero = (len_full == 16'd0);
    status.body_last = ((PTR_W + 1)'(byte_count) + 1'b1) >= (PTR_W + 1)'(len);
    status.chk_bad = chk_bad;
    status.flen_zero = (len == '0);
    status.flen_lt2 = (len < PTR_W'(2));
    status.type_tel = (ram_q == telemetry_type);
    status.type_log = (ram_q == log_type);
    status.group_fits = ((PTR_W + 1)'(rd_ptr) + (PTR_W + 1)'(GROUP_BYTES + 4'd1))
                        <= (PTR_W + 1)'(len);
    status.out_free = !out_valid || out_ready;
  end

endmodule

// File: sv/tfd_ctrl.sv
// Controller state machine of the deframer: byte parsing and record sequencing.
module tfd_ctrl import tfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  status_t status,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic [3:0] fcnt;
  logic [3:0] fcnt_next;
  logic accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      fcnt <= '0;
    end else begin
      state <= state_next;
      fcnt <= fcnt_next;
    end
  end

  always_comb begin
    state_next = state;
    fcnt_next = fcnt;
    in_ready = 1'b0;
    cmd = '0;
    cmd.out_kind = KIND_SHORT;
    cmd.out_first_en = 1'b1;
    cmd.out_last = 1'b1;
    unique case (state)
      ST_HUNT: begin
        in_ready = 1'b1;
        if (accept && status.sync0) begin
          state_next = ST_SYNC;
        end
      end
      ST_SYNC: begin
        in_ready = 1'b1;
        if (accept) begin
          state_next = status.sync1 ? ST_LENLO : ST_HUNT;
        end
      end
      ST_LENLO: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.len_lo_ld = 1'b1;
          state_next = ST_LENHI;
        end
      end
      ST_LENHI: begin
        in_ready = status.out_free;
        if (accept) begin
          cmd.len_hi_ld = 1'b1;
          if (status.len_over) begin
            cmd.out_ld = 1'b1;
            cmd.out_kind = KIND_OVERSIZE;
            cmd.out_first_en = 1'b0;
            state_next = ST_HUNT;
          end else begin
            state_next = status.len_zero ? ST_CHECK : ST_BODY;
          end
        end
      end
      ST_BODY: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.body_wr = 1'b1;
          if (status.body_last) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.check_ld = 1'b1;
          state_next = ST_EVAL0;
        end
      end
      ST_EVAL0: begin
        cmd.eval = 1'b1;
        state_next = ST_EVAL1;
      end
      ST_EVAL1: begin
        if (status.chk_bad) begin
          cmd.out_kind = KIND_CSUM_BAD;
        end else if (status.flen_zero) begin
          cmd.out_kind = KIND_SHORT;
        end else if (status.type_tel) begin
          cmd.out_kind = KIND_SHORT;
        end else if (status.type_log) begin
          cmd.out_kind = KIND_SHORT;
        end else begin
          cmd.out_kind = KIND_UNKNOWN;
        end
        if (!status.chk_bad && !status.flen_zero && !status.flen_lt2
            && status.type_tel) begin
          cmd.ptr_set1 = 1'b1;
          state_next = ST_JCHK;
        end else if (!status.chk_bad && !status.flen_zero && !status.flen_lt2
                     && status.type_log) begin
          cmd.ptr_set1 = 1'b1;
          state_next = ST_LOGRD;
        end else if (status.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = ST_HUNT;
        end
      end
      ST_JCHK: begin
        fcnt_next = '0;
        state_next = status.group_fits ? ST_JFETCH : ST_ENDRD;
      end
      ST_JFETCH: begin
        cmd.fetch_adv = (fcnt != GROUP_BYTES);
        cmd.fetch_shift = (fcnt != 4'd0);
        fcnt_next = fcnt + 4'd1;
        if (fcnt == GROUP_BYTES) begin
          state_next = ST_JOUT;
        end
      end
      ST_JOUT: begin
        cmd.out_kind = KIND_JOINT;
        cmd.out_last = 1'b0;
        if (status.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.jidx_inc = 1'b1;
          state_next = ST_JCHK;
        end
      end
      ST_ENDRD: begin
        state_next = ST_ENDOUT;
      end
      ST_ENDOUT: begin
        cmd.out_kind = KIND_TEL_END;
        if (status.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = ST_HUNT;
        end
      end
      ST_LOGRD: begin
        state_next = ST_LOGOUT;
      end
      ST_LOGOUT: begin
        cmd.out_kind = KIND_LOG;
        if (status.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = ST_HUNT;
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

endmodule

// File: sv/telemetry_frame_deframer.sv
// Top level of the telemetry frame deframer: APB register decode and block integration.
//
//   channel   direction  transfer                 contents
//   s_*       in         one received byte        s_tdata[7:0] rx_byte
//   m_*       out        one result record        tdata fields, tuser kind, tlast last
//   APB       in/out     register write or read   telemetry_type at 0x0, log_type at 0x4
//
// Header, length, payload and checksum bytes are taken as they arrive; the high length
// byte waits while the result register is full. Then EVAL0 and EVAL1 fetch the type and
// give any status record; each joint record takes a group check (JCHK), 12 byte reads
// (JFETCH) and an output (JOUT), the end record JCHK, ENDRD and ENDOUT, the log record
// LOGRD and LOGOUT, plus any output stall. No input is taken during that sequence.
// Reset clears control state only; the payload memory is not cleared.
module telemetry_frame_deframer import tfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 512
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,           // [7:0] rx_byte
  output logic m_tvalid,
  input  logic m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [5:0] joint_index, [37:6] position_word,
                                        // [69:38] velocity_word, [101:70] accel_word,
                                        // [109:102] state_byte, [111:110] log_level,
                                        // [127:112] message_length, [128] first_frame
  output logic [2:0] m_tuser,           // [2:0] kind
  output logic m_tlast,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  cmd_t cmd;
  status_t status;
  cfg_wr_t cfg_wr;
  record_t out_rec;
  kind_t out_kind;

  assign pready = 1'b1;
  assign cfg_wr.we = psel && penable && pwrite && pready;
  assign cfg_wr.sel = paddr[2];
  assign cfg_wr.data = pwdata[7:0];

  tfd_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .status(status),
    .cmd(cmd)
  );

  tfd_datapath #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .rx_byte(s_tdata),
    .cfg_wr(cfg_wr),
    .cfg_rsel(paddr[2]),
    .cfg_rdata(prdata),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_rec(out_rec),
    .out_kind(out_kind),
    .out_last(m_tlast)
  );

  assign m_tdata = out_rec;
  assign m_tuser = out_kind;

endmodule

// File: sim/tfd_checker.sv
// Checker for the telemetry frame deframer: predicts every record and compares output transfers.
`timescale 1ns / 100ps
module tfd_checker import tfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 512
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [7:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  input  logic [2:0] m_tuser,
  input  logic m_tlast,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic pready,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output int errors,
  output int pending
);

  typedef struct packed {
    kind_t kind;
    record_t rec;
    logic last;
  } framed_record_t;

  framed_record_t expected_records[$];
  int mismatches;

  state_t phase;
  logic [15:0] frame_len;
  logic [15:0] byte_cnt;
  logic [7:0] payload_xor;
  logic [7:0] payload_mem [MAX_PAYLOAD];
  logic valid_seen;
  logic [7:0] tel_type;
  logic [7:0] log_type;

  function automatic logic [7:0] payload_at(int unsigned i);
    if (i >= MAX_PAYLOAD) return 8'h00;
    return payload_mem[i];
  endfunction

  function automatic logic [31:0] word_at(int unsigned i);
    return {payload_at(i + 3), payload_at(i + 2), payload_at(i + 1), payload_at(i)};
  endfunction

  task automatic push_record(input kind_t k, input logic [5:0] idx, input logic [31:0] pos,
                             input logic [31:0] vel, input logic [31:0] acc,
                             input logic [7:0] state, input logic [1:0] lvl,
                             input logic [15:0] mlen, input logic first, input logic last);
    framed_record_t r;
    r.kind = k;
    r.rec.pad = '0;
    r.rec.first_frame = first;
    r.rec.message_length = mlen;
    r.rec.log_level = lvl;
    r.rec.state_byte = state;
    r.rec.accel_word = acc;
    r.rec.velocity_word = vel;
    r.rec.position_word = pos;
    r.rec.joint_index = idx;
    r.last = last;
    expected_records.push_back(r);
  endtask

  task automatic finish_payload(input logic [7:0] chk);
    logic first;
    logic [7:0] lvl;
    int unsigned joints;
    int unsigned base;
    int unsigned j;
    if (chk != payload_xor) begin
      push_record(KIND_CSUM_BAD, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1);
    end else if (frame_len == 0) begin
      push_record(KIND_SHORT, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1);
    end else begin
      first = !valid_seen;
      valid_seen = 1'b1;
      if (payload_at(0) == tel_type) begin
        if (frame_len < 2) begin
          push_record(KIND_SHORT, 0, 0, 0, 0, 0, 0, 0, first, 1'b1);
        end else begin
          joints = (frame_len - 2) / GROUP_BYTES;
          base = 1;
          for (j = 0; j < joints; j++) begin
            push_record(KIND_JOINT, j[5:0], word_at(base), word_at(base + WORD_BYTES),
                        word_at(base + 2 * WORD_BYTES), 0, 0, 0, first, 1'b0);
            base += GROUP_BYTES;
          end
          push_record(KIND_TEL_END, 0, 0, 0, 0, payload_at(base), 0, 0, first, 1'b1);
        end
      end else if (payload_at(0) == log_type) begin
        if (frame_len < 2) begin
          push_record(KIND_SHORT, 0, 0, 0, 0, 0, 0, 0, first, 1'b1);
        end else begin
          lvl = payload_at(1);
          if (lvl > 3) lvl = 8'h00;
          push_record(KIND_LOG, 0, 0, 0, 0, 0, lvl[1:0], frame_len - 16'd2, first, 1'b1);
        end
      end else begin
        push_record(KIND_UNKNOWN, 0, 0, 0, 0, 0, 0, 0, first, 1'b1);
      end
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    case (phase)
      ST_SYNC: phase = (b == SYNC_BYTE1) ? ST_LENLO : ST_HUNT;
      ST_LENLO: begin
        frame_len = {8'h00, b};
        phase = ST_LENHI;
      end
      ST_LENHI: begin
        frame_len[15:8] = b;
        byte_cnt = '0;
        payload_xor = '0;
        if (frame_len > MAX_PAYLOAD) begin
          push_record(KIND_OVERSIZE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1);
          phase = ST_HUNT;
        end else begin
          phase = (frame_len == 0) ? ST_CHECK : ST_BODY;
        end
      end
      ST_BODY: begin
        if (byte_cnt < MAX_PAYLOAD) payload_mem[byte_cnt] = b;
        payload_xor ^= b;
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt >= frame_len) phase = ST_CHECK;
      end
      ST_CHECK: begin
        finish_payload(b);
        phase = ST_HUNT;
      end
      default: phase = (b == SYNC_BYTE0) ? ST_SYNC : ST_HUNT;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_record();
    framed_record_t want;
    record_t got;
    got = record_t'(m_tdata);
    if (expected_records.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected record, expected none, actual kind %0d", $time, m_tuser);
    end else begin
      want = expected_records.pop_front();
      check_field("kind", 32'(want.kind), 32'(m_tuser));
      check_field("joint_index", 32'(want.rec.joint_index), 32'(got.joint_index));
      check_field("position_word", want.rec.position_word, got.position_word);
      check_field("velocity_word", want.rec.velocity_word, got.velocity_word);
      check_field("accel_word", want.rec.accel_word, got.accel_word);
      check_field("state_byte", 32'(want.rec.state_byte), 32'(got.state_byte));
      check_field("log_level", 32'(want.rec.log_level), 32'(got.log_level));
      check_field("message_length", 32'(want.rec.message_length), 32'(got.message_length));
      check_field("first_frame", 32'(want.rec.first_frame), 32'(got.first_frame));
      check_field("last", 32'(want.last), 32'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase = ST_HUNT;
      frame_len = '0;
      byte_cnt = '0;
      payload_xor = '0;
      valid_seen = 1'b0;
      tel_type = 8'd1;
      log_type = 8'd240;
      mismatches = 0;
      expected_records.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LOG_TYPE) log_type = pwdata[7:0];
        else tel_type = pwdata[7:0];
      end
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
      if (m_tvalid && m_tready) compare_record();
      pending <= expected_records.size();
      errors <= mismatches;
    end
  end

endmodule

// File: sim/tb.sv
// Testbench top for the telemetry frame deframer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb import tfd_pkg::*; ();

  localparam int MAX_PAYLOAD = 512;
  localparam int HOLD_CYCLES = 1500;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  int errors;
  int pending;
  int quiet;
  int sent_bytes = 0;
  logic tx_gaps = 1'b1;
  logic rx_gaps = 1'b1;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic [7:0] tel_cfg = 8'd1;
  logic [7:0] log_cfg = 8'd240;
  logic [7:0] body[$];

  telemetry_frame_deframer #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tfd_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= !rx_gaps || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  initial begin
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps) begin
      while ($urandom_range(0, 99) < 10) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
  endtask

  task automatic fill_body(input int unsigned len, input logic [7:0] kind_byte);
    int unsigned i;
    body.delete();
    for (i = 0; i < len; i++) body.push_back((i == 0) ? kind_byte : 8'($urandom()));
  endtask

  task automatic send_frame(input logic corrupt);
    logic [7:0] sum;
    logic [15:0] len;
    int unsigned i;
    sum = 8'h00;
    len = 16'(body.size());
    foreach (body[i]) sum ^= body[i];
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    send_byte(SYNC_BYTE0);
    send_byte(SYNC_BYTE1);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (i = 0; i < body.size(); i++) send_byte(body[i]);
    send_byte(sum);
  endtask

  task automatic send_oversize(input logic [15:0] len);
    send_byte(SYNC_BYTE0);
    send_byte(SYNC_BYTE1);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LOG_TYPE) log_cfg = value;
    else tel_cfg = value;
  endtask

  task automatic set_types(input logic [7:0] tel, input logic [7:0] log_t);
    settle();
    write_reg(REG_TELEMETRY_TYPE, tel);
    write_reg(REG_LOG_TYPE, log_t);
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
      fill_body(2 + GROUP_BYTES * n + $urandom_range(0, 11), tel_cfg);
      send_frame(1'b0);
    end else if (pick < 58) begin
      fill_body($urandom_range(2, 20), log_cfg);
      body[1] = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom());
      send_frame(1'b0);
    end else if (pick < 66) begin
      fill_body($urandom_range(1, 30), 8'($urandom()));
      send_frame(1'b0);
    end else if (pick < 74) begin
      fill_body($urandom_range(0, 30), $urandom_range(0, 1) ? tel_cfg : 8'($urandom()));
      send_frame(1'b1);
    end else if (pick < 79) begin
      send_oversize(16'($urandom_range(MAX_PAYLOAD + 1, 65535)));
    end else if (pick < 85) begin
      fill_body($urandom_range(0, 1), (pick < 82) ? tel_cfg : log_cfg);
      send_frame(1'b0);
    end else if (pick < 92) begin
      send_byte(SYNC_BYTE0);
      if ($urandom_range(0, 1)) begin
        send_byte(SYNC_BYTE0);
        send_byte(SYNC_BYTE1);
      end else begin
        do b = 8'($urandom()); while (b == SYNC_BYTE1);
        send_byte(b);
      end
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) send_byte(8'($urandom()));
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = sent_bytes + count;
    while (sent_bytes < target) begin
      send_random_frame();
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_BYTE1);
    send_byte(SYNC_BYTE0);
    send_byte(8'h00);
    send_byte(SYNC_BYTE0);
    send_byte(SYNC_BYTE0);
    send_byte(SYNC_BYTE1);
    body.delete();
    send_frame(1'b0);
    send_frame(1'b1);
    send_oversize(16'(MAX_PAYLOAD + 1));
    send_oversize(16'hFFFF);
    fill_body(14, tel_cfg);
    send_frame(1'b1);
    fill_body(1, tel_cfg);
    send_frame(1'b0);
    fill_body(1, log_cfg);
    send_frame(1'b0);
    fill_body(2, tel_cfg);
    send_frame(1'b0);
    fill_body(14, tel_cfg);
    body[1] = 8'hFF; body[2] = 8'hFF; body[3] = 8'hFF; body[4] = 8'hFF;
    body[5] = 8'h00; body[6] = 8'h00; body[7] = 8'h00; body[8] = 8'h00;
    body[13] = 8'hFF;
    send_frame(1'b0);
    fill_body(3, log_cfg);
    body[1] = 8'd3;
    send_frame(1'b0);
    fill_body(2, log_cfg);
    body[1] = 8'hFF;
    send_frame(1'b0);
    fill_body(5, 8'h00);
    send_frame(1'b0);

    set_types(8'd0, 8'd255);
    run_random(40);

    set_types(8'd255, 8'd0);
    run_random(40);

    set_types(8'd7, 8'd7);
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    run_random(70);
    drain();
    tx_gaps = 1'b1;
    rx_gaps <= 1'b1;

    set_types(8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)));
    hold_req <= 1'b1;
    fill_body(2 + GROUP_BYTES * 6, tel_cfg);
    send_frame(1'b0);
    run_random(15);

    set_types(8'd1, 8'd240);
    run_random(35);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
